// ===== design/dht_pkg.sv =====
package dht_pkg;

    // Default geometry of the table.
    localparam int TABLE_SLOTS_DEF = 13;
    localparam int STEP_PRIME_DEF  = 11;
    localparam int KEY_BYTES_DEF   = 9;

    // Fixed field widths.
    localparam int BYTE_W   = 8;
    localparam int HEAD_W   = 64;
    localparam int TAIL_W   = 8;
    localparam int KEY_W    = HEAD_W + TAIL_W;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int MAX_KEY_BYTES = KEY_W / BYTE_W;

    // Operation carried in the input tuser.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

endpackage

// ===== design/dht_mod.sv =====
// Remainder of an unsigned dividend by a constant divisor. At start the dividend and
// the quotient are registered; the quotient comes from a multiplication by a scaled
// reciprocal that is exact for every dividend of DVD_W bits. The remainder, the
// dividend minus quotient times divisor, is then registered while busy, and done rises with it.
module dht_mod #(
    parameter int DVD_W   = 12,
    parameter int DIVISOR = 13,
    parameter int REM_W   = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    output logic             busy,
    output logic             done,
    output logic [REM_W-1:0] rem
);

    localparam int SHIFT   = DVD_W + $clog2(DIVISOR);
    localparam int RECIP_W = DVD_W + 2;
    localparam int PROD_W  = DVD_W + RECIP_W;
    localparam int QUOT_W  = PROD_W - SHIFT;
    localparam longint RECIP_VAL =
        ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam logic [DVD_W-1:0]   DIV_C = DVD_W'(DIVISOR);

    logic [DVD_W-1:0]  dvd_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod;
    logic [DVD_W-1:0]  rem_full;

    assign prod     = PROD_W'(dividend) * PROD_W'(RECIP);
    assign rem_full = dvd_reg - DVD_W'(DVD_W'(quot_reg) * DIV_C);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            quot_reg <= prod[SHIFT +: QUOT_W];
        end
        if (busy_reg) begin
            rem_reg <= REM_W'(rem_full);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/double_hash_table_insert_search.sv =====
// Double-hashing hash table with insert and search of short text keys.
//
// Input channel (s_): one item is one operation. s_tuser selects insert or search,
// s_tdata carries the key, byte 0 in the lowest bits, zero padded. The key ends at
// its first zero byte. Result channel (m_): one item per operation, a status and
// the slot that was written or found (zero for errors and misses).
//
// The block works on one operation at a time. After an item is taken the home
// slot, the probe step and the step reduced to the table size are each formed in
// turn by a remainder unit for a constant divisor. The walk then reads one table
// slot per cycle from the key memory, probing 1 to TABLE_SLOTS slots, and the next
// item is taken only once the result has moved into the output register. An empty
// key goes straight to the result without the remainder units or the walk.
//
// After reset the block sweeps the memory once to mark every slot free, with
// s_tready low meanwhile. The result sits in an output register; while the
// receiver stalls, the next operation is taken and worked out, and it holds
// s_tready low until the waiting result has been taken.
module double_hash_table_insert_search #(
    parameter int TABLE_SLOTS = dht_pkg::TABLE_SLOTS_DEF,
    parameter int STEP_PRIME  = dht_pkg::STEP_PRIME_DEF,
    parameter int KEY_BYTES   = dht_pkg::KEY_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [dht_pkg::KEY_W-1:0] s_tdata,  // key_head [63:0], key_tail [71:64]
    input  logic                     s_tuser,  // kind [0]: 0 insert, 1 search
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata   // status [2:0], slot [6:3], zero [7]
);

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int PRIME_W = $clog2(STEP_PRIME);
    localparam int SUM_W   = $clog2(KEY_BYTES * 255 + 1);
    localparam int DIV_MAX = (TABLE_SLOTS > STEP_PRIME) ? TABLE_SLOTS : STEP_PRIME;
    localparam int DIV_W   = $clog2(DIV_MAX + 1);
    localparam int DVD_W   = (SUM_W > DIV_W) ? SUM_W : DIV_W;
    localparam int ENTRY_W = dht_pkg::KEY_W + 1;
    localparam int NBYTES  = dht_pkg::MAX_KEY_BYTES;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_HOME,
        S_STEPR,
        S_STEPM,
        S_PROBE,
        S_CHECK,
        S_RESP
    } state_t;

    state_t                    state_reg;
    logic [IDX_W-1:0]          clr_idx_reg;
    logic                      kind_reg;
    logic [dht_pkg::KEY_W-1:0] key_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [IDX_W-1:0]          home_reg;
    logic [IDX_W-1:0]          stepm_reg;
    logic [IDX_W-1:0]          idx_reg;
    dht_pkg::status_t          res_status_reg;
    logic [dht_pkg::SLOT_W-1:0] res_slot_reg;
    logic                      m_tvalid_reg;
    logic [7:0]                m_tdata_reg;

    // Key memory: occupancy mark in the top bit, the cut key below it.
    logic [ENTRY_W-1:0] mem [TABLE_SLOTS];
    logic [ENTRY_W-1:0] rd_q_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic                      slots_start;
    logic [DVD_W-1:0]          slots_dividend;
    logic                      slots_busy;
    logic                      slots_done;
    logic [IDX_W-1:0]          slots_rem;
    logic                      prime_start;
    logic [DVD_W-1:0]          prime_dividend;
    logic                      prime_busy;
    logic                      prime_done;
    logic [PRIME_W-1:0]        prime_rem;

    logic [dht_pkg::KEY_W-1:0] cut_key;
    logic [SUM_W-1:0]          cut_sum;
    logic                      alive;
    logic [dht_pkg::BYTE_W-1:0] kbyte;
    logic                      slot_occ;
    logic                      slot_match;
    logic [IDX_W:0]            probe_sum;
    logic [IDX_W-1:0]          probe_next;

    // Cut the incoming key at its first zero byte and at KEY_BYTES, and sum it.
    always_comb begin
        cut_key = '0;
        cut_sum = '0;
        alive   = 1'b1;
        for (int b = 0; b < NBYTES; b++) begin
            kbyte = s_tdata[b*dht_pkg::BYTE_W +: dht_pkg::BYTE_W];
            if (kbyte == '0 || b >= KEY_BYTES) begin
                alive = 1'b0;
            end
            if (alive) begin
                cut_key[b*dht_pkg::BYTE_W +: dht_pkg::BYTE_W] = kbyte;
                cut_sum = cut_sum + SUM_W'(kbyte);
            end
        end
    end

    // Next probe position, wrapped into the table.
    always_comb begin
        probe_sum = {1'b0, idx_reg} + {1'b0, stepm_reg};
        if (probe_sum >= (IDX_W+1)'(TABLE_SLOTS)) begin
            probe_sum = probe_sum - (IDX_W+1)'(TABLE_SLOTS);
        end
        probe_next = IDX_W'(probe_sum);
    end

    assign slot_occ   = rd_q_reg[ENTRY_W-1];
    assign slot_match = (rd_q_reg[dht_pkg::KEY_W-1:0] == key_reg);

    // Remainder requests: home = sum mod slots, step = prime - home mod prime,
    // then the step is reduced mod slots so a wrap needs only one subtraction.
    assign prime_dividend = DVD_W'(slots_rem);

    always_comb begin
        slots_start    = 1'b0;
        slots_dividend = DVD_W'(sum_reg);
        prime_start    = 1'b0;
        unique case (state_reg)
            S_START: begin
                slots_start = (key_reg[dht_pkg::BYTE_W-1:0] != '0);
            end
            S_HOME: begin
                prime_start = slots_done;
            end
            S_STEPR: begin
                slots_start    = prime_done;
                slots_dividend = DVD_W'(STEP_PRIME) - DVD_W'(prime_rem);
            end
            default: begin
                slots_start = 1'b0;
            end
        endcase
    end

    dht_mod #(
        .DVD_W   (DVD_W),
        .DIVISOR (TABLE_SLOTS),
        .REM_W   (IDX_W)
    ) u_mod_slots (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (slots_start),
        .dividend (slots_dividend),
        .busy     (slots_busy),
        .done     (slots_done),
        .rem      (slots_rem)
    );

    dht_mod #(
        .DVD_W   (DVD_W),
        .DIVISOR (STEP_PRIME),
        .REM_W   (PRIME_W)
    ) u_mod_prime (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (prime_start),
        .dividend (prime_dividend),
        .busy     (prime_busy),
        .done     (prime_done),
        .rem      (prime_rem)
    );

    // Memory port control.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = {1'b1, key_reg};
        rd_addr = home_reg;
        unique case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = '0;
            end
            S_CHECK: begin
                wr_en   = !slot_occ && (kind_reg == dht_pkg::KIND_INSERT);
                rd_addr = probe_next;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A taken result leaves the output register, unless a new one moves in.
            if (m_tvalid_reg && m_tready && state_reg != S_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == IDX_W'(TABLE_SLOTS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg  <= s_tuser;
                        key_reg   <= cut_key;
                        sum_reg   <= cut_sum;
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    if (key_reg[dht_pkg::BYTE_W-1:0] == '0) begin
                        // Empty key: nothing stored, nothing found.
                        res_status_reg <= (kind_reg == dht_pkg::KIND_SEARCH)
                                          ? dht_pkg::STAT_NOT_FOUND
                                          : dht_pkg::STAT_INSERTED;
                        res_slot_reg   <= '0;
                        state_reg      <= S_RESP;
                    end else begin
                        state_reg <= S_HOME;
                    end
                end
                S_HOME: begin
                    if (slots_done) begin
                        home_reg  <= slots_rem;
                        state_reg <= S_STEPR;
                    end
                end
                S_STEPR: begin
                    if (prime_done) begin
                        state_reg <= S_STEPM;
                    end
                end
                S_STEPM: begin
                    if (slots_done) begin
                        stepm_reg <= slots_rem;
                        idx_reg   <= home_reg;
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    // Home slot read is in flight.
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    priority if (!slot_occ) begin
                        if (kind_reg == dht_pkg::KIND_INSERT) begin
                            res_status_reg <= dht_pkg::STAT_INSERTED;
                            res_slot_reg   <= dht_pkg::SLOT_W'(idx_reg);
                        end else begin
                            res_status_reg <= dht_pkg::STAT_NOT_FOUND;
                            res_slot_reg   <= '0;
                        end
                        state_reg <= S_RESP;
                    end else if (slot_match) begin
                        if (kind_reg == dht_pkg::KIND_SEARCH) begin
                            res_status_reg <= dht_pkg::STAT_FOUND;
                            res_slot_reg   <= dht_pkg::SLOT_W'(idx_reg);
                        end else begin
                            res_status_reg <= dht_pkg::STAT_DUPLICATE;
                            res_slot_reg   <= '0;
                        end
                        state_reg <= S_RESP;
                    end else if (probe_next == home_reg) begin
                        // The walk came back home without a free slot or a match.
                        res_status_reg <= (kind_reg == dht_pkg::KIND_SEARCH)
                                          ? dht_pkg::STAT_NOT_FOUND
                                          : dht_pkg::STAT_FULL;
                        res_slot_reg   <= '0;
                        state_reg      <= S_RESP;
                    end else begin
                        // The next slot is being read this cycle.
                        idx_reg <= probe_next;
                    end
                end
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, res_slot_reg, res_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An insert that writes a slot always reports that slot as inserted.
    a_write_reports_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && state_reg == S_CHECK) |=>
            (res_status_reg == dht_pkg::STAT_INSERTED && state_reg == S_RESP))
        else $error("slot write without an inserted status");

    // A new operation is never taken while a remainder unit is still working.
    a_ready_mod_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(slots_busy || prime_busy))
        else $error("input ready while a remainder unit is busy");

    // The probe position never leaves the table.
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |->
            ({1'b0, idx_reg} < (IDX_W+1)'(TABLE_SLOTS) &&
             {1'b0, probe_next} < (IDX_W+1)'(TABLE_SLOTS)))
        else $error("probe index outside the table");

    // Only inserted and found results carry a slot number.
    a_slot_zero_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == dht_pkg::STAT_INSERTED ||
                      m_tdata[2:0] == dht_pkg::STAT_FOUND ||
                      m_tdata[6:3] == '0))
        else $error("nonzero slot on an error or miss result");

endmodule
